@@ src/tsls_pkg.sv @@
// Shared types and constants for the tour swap local search block.
// No dependencies; compiled before every other file of the block.
package tsls_pkg;

   // Default number of cities the distance store and tour are sized for
   localparam int MAX_CITIES_DEF = 64;

   // Fixed field widths
   localparam int CMD_W  = 2;
   localparam int POS_W  = 6;
   localparam int DIST_W = 10;
   localparam int COST_W = 16;
   localparam int CITY_W = 6;
   localparam int CNT_W  = 7;

   localparam logic [COST_W-1:0] COST_MAX  = 16'hFFFF;
   localparam logic [CNT_W-1:0]  CNT_RESET = 7'd64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWAP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [POS_W-1:0]  pos_a;
      logic [POS_W-1:0]  pos_b;
      logic [DIST_W-1:0] distance;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] tour_cost;
      logic              improved;
      logic [COST_W-1:0] best_cost;
      logic [CITY_W-1:0] city;
      logic              error;
   } rsp_type;

endpackage

@@ src/tsls_chan_if.sv @@
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; used with the types of tsls_pkg.
interface tsls_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/tour_swap_local_search.sv @@
// Tour swap local search: distance store, tour memory and a shared tour-cost accumulator.
// After reset the distance store is swept to zero; no transaction is taken during the sweep.
// One transaction at a time; a swap walks the tour of the clamped city_count,
// with one distance read and one add per tour edge.
// Result sits in an output register; the next request is taken while it waits.
// Reset is synchronous, active high; tour returns to identity, best cost to 65535.
module tour_swap_local_search #(
   parameter int MAX_CITIES = tsls_pkg::MAX_CITIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   tsls_chan_if.sink                  req_if,
   tsls_chan_if.source                rsp_if,
   input  logic                       csr_we,
   input  logic [tsls_pkg::CNT_W-1:0] csr_wdata
);
   import tsls_pkg::*;

   localparam int CW     = (MAX_CITIES > 2) ? $clog2(MAX_CITIES) : 1;
   localparam int DDEPTH = MAX_CITIES * MAX_CITIES;
   localparam int AW     = $clog2(DDEPTH);
   localparam int CNTW   = $clog2(MAX_CITIES + 2);

   // Sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LD_WR0 = 4'd2;
   localparam logic [3:0] S_LD_WR1 = 4'd3;
   localparam logic [3:0] S_SW_RD  = 4'd4;
   localparam logic [3:0] S_SW_WR0 = 4'd5;
   localparam logic [3:0] S_SW_WR1 = 4'd6;
   localparam logic [3:0] S_EVAL   = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_RD_RD  = 4'd9;
   localparam logic [3:0] S_RD_TAKE = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   // Memories
   logic [DIST_W-1:0] dist_mem [DDEPTH];
   logic [CW-1:0]     tour_mem [MAX_CITIES];

   // Registers and next values
   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     pa_ff, pa_in, pb_ff, pb_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]  city_count_ff, city_count_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [COST_W-1:0] res_cost_ff, res_cost_in;
   logic              res_imp_ff, res_imp_in;
   logic [CITY_W-1:0] res_city_ff, res_city_in;
   logic              res_err_ff, res_err_in;
   logic [CNTW-1:0]   iss_ff, iss_in;
   logic              t_vld_ff, t_vld_in, t_first_ff, t_first_in, t_last_ff, t_last_in;
   logic              d_vld_ff, d_vld_in, d_last_ff, d_last_in;
   logic [CW-1:0]     prev_ff, prev_in;
   logic [COST_W-1:0] sum_ff, sum_in;
   logic [CW-1:0]     hold_ff, hold_in;
   logic [MAX_CITIES-1:0] tv_ff, tv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Memory read registers
   logic [CW-1:0]     ta_q_ff, tb_q_ff, ta_i_ff, tb_i_ff;
   logic              ta_v_ff, tb_v_ff;
   logic [DIST_W-1:0] dq_ff;

   // Memory ports
   logic [CW-1:0]     ta_addr, tb_addr, tw_addr, tw_data;
   logic              tw_en;
   logic [AW-1:0]     dw_addr, dr_addr;
   logic [DIST_W-1:0] dw_data;
   logic              dw_en;

   // Derived values
   logic [CNTW-1:0]   act_cnt;
   logic [CW-1:0]     eff_a, eff_b;
   logic [COST_W:0]   sum_ext;
   logic              accept;
   req_type           req;

   assign req    = req_if.payload;
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Entries never written since restart read as their own index
   assign eff_a = ta_v_ff ? ta_q_ff : ta_i_ff;
   assign eff_b = tb_v_ff ? tb_q_ff : tb_i_ff;

   // Saturating tour-cost add
   assign sum_ext = {1'b0, sum_ff} + (COST_W + 1)'(dq_ff);

   // City count held within [2, MAX_CITIES]
   always_comb begin
      if (city_count_ff < CNT_W'(2)) begin
         act_cnt = CNTW'(2);
      end else if (32'(city_count_ff) > MAX_CITIES) begin
         act_cnt = CNTW'(MAX_CITIES);
      end else begin
         act_cnt = CNTW'(city_count_ff);
      end
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      dist_in       = dist_ff;
      cnt_in        = cnt_ff;
      city_count_in = csr_we ? csr_wdata : city_count_ff;
      best_in       = best_ff;
      res_cost_in   = res_cost_ff;
      res_imp_in    = res_imp_ff;
      res_city_in   = res_city_ff;
      res_err_in    = res_err_ff;
      iss_in        = iss_ff;
      t_vld_in      = 1'b0;
      t_first_in    = 1'b0;
      t_last_in     = 1'b0;
      d_vld_in      = 1'b0;
      d_last_in     = 1'b0;
      prev_in       = prev_ff;
      sum_in        = sum_ff;
      hold_in       = hold_ff;
      tv_in         = tv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      ta_addr       = pa_ff;
      tb_addr       = pb_ff;
      tw_en         = 1'b0;
      tw_addr       = pa_ff;
      tw_data       = eff_b;
      dw_en         = 1'b0;
      dw_addr       = clr_ff;
      dw_data       = '0;
      dr_addr       = '0;

      case (state_ff)
         S_CLEAR: begin
            dw_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == DDEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               pa_in       = CW'(req.pos_a);
               pb_in       = CW'(req.pos_b);
               dist_in     = req.distance;
               cnt_in      = act_cnt;
               res_cost_in = '0;
               res_imp_in  = 1'b0;
               res_city_in = '0;
               res_err_in  = 1'b0;
               case (req.command)
                  CMD_LOAD: begin
                     if (32'(req.pos_a) >= MAX_CITIES || 32'(req.pos_b) >= MAX_CITIES) begin
                        res_err_in = 1'b1;
                        state_in   = S_DONE;
                     end else begin
                        state_in = S_LD_WR0;
                     end
                  end
                  CMD_SWAP: begin
                     if (32'(req.pos_a) >= 32'(act_cnt) || 32'(req.pos_b) >= 32'(act_cnt)) begin
                        res_err_in = 1'b1;
                        state_in   = S_DONE;
                     end else begin
                        state_in = S_SW_RD;
                     end
                  end
                  CMD_RESTART: begin
                     tv_in    = '0;
                     best_in  = COST_MAX;
                     state_in = S_DONE;
                  end
                  CMD_READ: begin
                     if (32'(req.pos_a) >= 32'(act_cnt)) begin
                        res_err_in = 1'b1;
                        state_in   = S_DONE;
                     end else begin
                        state_in = S_RD_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // Symmetric distance write, one entry per cycle
         S_LD_WR0: begin
            dw_en    = 1'b1;
            dw_addr  = AW'(32'(pa_ff) * MAX_CITIES + 32'(pb_ff));
            dw_data  = dist_ff;
            state_in = S_LD_WR1;
         end
         S_LD_WR1: begin
            dw_en    = 1'b1;
            dw_addr  = AW'(32'(pb_ff) * MAX_CITIES + 32'(pa_ff));
            dw_data  = dist_ff;
            state_in = S_DONE;
         end
         // Swap: read both positions, then write them back crossed
         S_SW_RD: begin
            state_in = S_SW_WR0;
         end
         S_SW_WR0: begin
            hold_in     = eff_a;
            tw_en       = 1'b1;
            tw_addr     = pa_ff;
            tw_data     = eff_b;
            tv_in[pa_ff] = 1'b1;
            state_in    = S_SW_WR1;
         end
         S_SW_WR1: begin
            tw_en       = 1'b1;
            tw_addr     = pb_ff;
            tw_data     = hold_ff;
            tv_in[pb_ff] = 1'b1;
            iss_in      = '0;
            sum_in      = '0;
            state_in    = S_EVAL;
         end
         // Tour walk: tour read, then distance read, then accumulate
         S_EVAL: begin
            if (iss_ff <= cnt_ff) begin
               ta_addr    = (iss_ff == cnt_ff) ? '0 : CW'(iss_ff);
               t_vld_in   = 1'b1;
               t_first_in = (iss_ff == '0);
               t_last_in  = (iss_ff == cnt_ff);
               iss_in     = iss_ff + CNTW'(1);
            end
            if (t_vld_ff) begin
               prev_in = eff_a;
               if (!t_first_ff) begin
                  dr_addr   = AW'(32'(prev_ff) * MAX_CITIES + 32'(eff_a));
                  d_vld_in  = 1'b1;
                  d_last_in = t_last_ff;
               end
            end
            if (d_vld_ff) begin
               sum_in = sum_ext[COST_W] ? COST_MAX : sum_ext[COST_W-1:0];
               if (d_last_ff) begin
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            res_cost_in = sum_ff;
            if (sum_ff < best_ff) begin
               best_in    = sum_ff;
               res_imp_in = 1'b1;
            end
            state_in = S_DONE;
         end
         S_RD_RD: begin
            state_in = S_RD_TAKE;
         end
         S_RD_TAKE: begin
            res_city_in = CITY_W'(eff_a);
            state_in    = S_DONE;
         end
         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.tour_cost = res_cost_ff;
               rsp_data_in.improved  = res_imp_ff;
               rsp_data_in.best_cost = best_ff;
               rsp_data_in.city      = res_city_ff;
               rsp_data_in.error     = res_err_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         city_count_ff <= CNT_RESET;
         best_ff       <= COST_MAX;
         tv_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         t_vld_ff      <= 1'b0;
         d_vld_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         city_count_ff <= city_count_in;
         best_ff       <= best_in;
         tv_ff         <= tv_in;
         rsp_valid_ff  <= rsp_valid_in;
         t_vld_ff      <= t_vld_in;
         d_vld_ff      <= d_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      dist_ff     <= dist_in;
      cnt_ff      <= cnt_in;
      res_cost_ff <= res_cost_in;
      res_imp_ff  <= res_imp_in;
      res_city_ff <= res_city_in;
      res_err_ff  <= res_err_in;
      iss_ff      <= iss_in;
      t_first_ff  <= t_first_in;
      t_last_ff   <= t_last_in;
      d_last_ff   <= d_last_in;
      prev_ff     <= prev_in;
      sum_ff      <= sum_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Tour memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (tw_en) begin
         tour_mem[tw_addr] <= tw_data;
      end
      ta_q_ff <= tour_mem[ta_addr];
      tb_q_ff <= tour_mem[tb_addr];
      ta_v_ff <= tv_ff[ta_addr];
      tb_v_ff <= tv_ff[tb_addr];
      ta_i_ff <= ta_addr;
      tb_i_ff <= tb_addr;
   end

   // Distance memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (dw_en) begin
         dist_mem[dw_addr] <= dw_data;
      end
      dq_ff <= dist_mem[dr_addr];
   end

endmodule
